// File: rtl/core/patm_pkg.sv
// Package for the pressure average threshold monitor.
// Holds window and scaling constants, reciprocal multipliers and shared types.
// No dependencies.
package patm_pkg;

    // Averaging window and converter full scale
    localparam int unsigned WINDOW         = 10;
    localparam int unsigned ADC_FULL_SCALE = 4095;
    localparam int unsigned PSI_SPAN       = 50;

    // Field widths
    localparam int unsigned SAMPLE_W   = 12;
    localparam int unsigned PSI_W      = 6;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned SAMPLE_MAX = (2 ** SAMPLE_W) - 1;

    // Stream bus widths (whole bytes)
    localparam int unsigned IN_FIELDS_W  = 3 * SAMPLE_W;
    localparam int unsigned OUT_FIELDS_W = 3 * PSI_W + STATUS_W;
    localparam int unsigned IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Ring pointer and running sum
    localparam int unsigned POS_W = $clog2(WINDOW);
    localparam int unsigned SUM_W = $clog2(WINDOW * SAMPLE_MAX + 1);

    // sum / WINDOW as (sum * DIV1_MULT) >> DIV1_S, exact for any SUM_W-bit sum
    localparam int unsigned DIV1_L  = $clog2(WINDOW);
    localparam int unsigned DIV1_S  = SUM_W + DIV1_L;
    localparam int unsigned DIV1_MW = SUM_W + 1;
    localparam logic [DIV1_MW-1:0] DIV1_MULT =
        DIV1_MW'(((64'd1 << DIV1_S) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
    localparam int unsigned PROD1_W = SUM_W + DIV1_MW;
    localparam int unsigned AVG_W   = SAMPLE_W;

    // avg * PSI_SPAN / ADC_FULL_SCALE, same reciprocal scheme
    localparam int unsigned SCALED_W = $clog2(SAMPLE_MAX * PSI_SPAN + 1);
    localparam int unsigned DIV2_L   = $clog2(ADC_FULL_SCALE);
    localparam int unsigned DIV2_S   = SCALED_W + DIV2_L;
    localparam int unsigned DIV2_MW  = SCALED_W + 1;
    localparam logic [DIV2_MW-1:0] DIV2_MULT =
        DIV2_MW'(((64'd1 << DIV2_S) + 64'(ADC_FULL_SCALE) - 64'd1)
                 / 64'(ADC_FULL_SCALE));
    localparam int unsigned PROD2_W  = SCALED_W + DIV2_MW;
    localparam int unsigned QUOT2_W  = PROD2_W - DIV2_S;

    typedef enum logic [STATUS_W-1:0] {
        LEVEL_NORMAL = 2'd0,
        LEVEL_HIGH   = 2'd1,
        LEVEL_LOW    = 2'd2
    } t_level_status;

    // Per-stage load enables sent to each channel
    typedef struct packed {
        logic upd;   // item enters sum stage: write ring, update running sum
        logic s2;    // load divide-by-window product
        logic s3;    // load scaled average
        logic s4;    // load divide-by-full-scale product
    } t_stage_en;

endpackage

// File: rtl/core/patm_channel.sv
// One averaging channel: sample ring, running sum and PSI scaling pipeline.
// Depends on patm_pkg.
module patm_channel (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  patm_pkg::t_stage_en           i_en,
    input  logic [patm_pkg::POS_W-1:0]    i_pos,
    input  logic [patm_pkg::SAMPLE_W-1:0] i_sample,
    output logic [patm_pkg::PSI_W-1:0]    o_psi
);
    import patm_pkg::*;

    logic [SAMPLE_W-1:0] r_ring [WINDOW];
    logic [SUM_W-1:0]    r_sum;
    logic [SUM_W-1:0]    n_sum;
    logic [PROD1_W-1:0]  r_prod1;
    logic [SCALED_W-1:0] r_scaled;
    logic [PROD2_W-1:0]  r_prod2;
    logic [AVG_W-1:0]    avg;
    logic [QUOT2_W-1:0]  quot;

    // drop oldest sample, add newest
    assign n_sum = r_sum - SUM_W'(r_ring[i_pos]) + SUM_W'(i_sample);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW; i++) begin
                r_ring[i] <= '0;
            end
            r_sum <= '0;
        end else if (i_en.upd) begin
            r_ring[i_pos] <= i_sample;
            r_sum         <= n_sum;
        end
    end

    assign avg = r_prod1[DIV1_S +: AVG_W];

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_prod1 <= PROD1_W'(r_sum) * PROD1_W'(DIV1_MULT);
        end
        if (i_en.s3) begin
            r_scaled <= SCALED_W'(avg) * SCALED_W'(PSI_SPAN);
        end
        if (i_en.s4) begin
            r_prod2 <= PROD2_W'(r_scaled) * PROD2_W'(DIV2_MULT);
        end
    end

    assign quot  = r_prod2[PROD2_W-1:DIV2_S];
    // clamp only matters when full scale is below the sample range
    assign o_psi = (32'(quot) > 32'(PSI_SPAN)) ? PSI_W'(PSI_SPAN) : PSI_W'(quot);

endmodule

// File: rtl/core/patm_status.sv
// Status compare and result register for the three scaled values.
// Depends on patm_pkg.
module patm_status (
    input  logic                         i_clk,
    input  logic                         i_load,
    input  logic [patm_pkg::PSI_W-1:0]   i_pressure_psi,
    input  logic [patm_pkg::PSI_W-1:0]   i_upper_psi,
    input  logic [patm_pkg::PSI_W-1:0]   i_lower_psi,
    output logic [patm_pkg::PSI_W-1:0]   o_pressure_psi,
    output logic [patm_pkg::PSI_W-1:0]   o_upper_psi,
    output logic [patm_pkg::PSI_W-1:0]   o_lower_psi,
    output patm_pkg::t_level_status      o_level_status
);
    import patm_pkg::*;

    t_level_status n_status;

    // high wins over low when the thresholds cross
    always_comb begin
        priority if (i_pressure_psi >= i_upper_psi) begin
            n_status = LEVEL_HIGH;
        end else if (i_pressure_psi <= i_lower_psi) begin
            n_status = LEVEL_LOW;
        end else begin
            n_status = LEVEL_NORMAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            o_pressure_psi <= i_pressure_psi;
            o_upper_psi    <= i_upper_psi;
            o_lower_psi    <= i_lower_psi;
            o_level_status <= n_status;
        end
    end

endmodule

// File: rtl/core/pressure_average_threshold_monitor.sv
// Top level of the pressure average threshold monitor.
// Depends on patm_pkg, patm_channel and patm_status.
//
// Usage:
//   Slave stream (i_s_*) takes one item per handshake: three 12-bit converter
//   samples (measured pressure, upper pot, lower pot). Master stream (o_m_*)
//   returns one item per input: the three 10-sample boxcar averages scaled to
//   whole PSI (0..50) and a level status (normal, high, low; high wins).
//   Path: an accepted item passes the input reg, sum, /window, *50, /full scale
//   and result reg stages before its result is shown on o_m_*.
//   Throughput: one item per cycle, sustained while i_m_tready is high.
//   Every stage holds its own valid bit and loads whenever it is empty or its
//   successor loads, so bubbles collapse and a new item is still taken while
//   a finished result waits. With the receiver stalled the pipeline fills and
//   o_s_tready drops after six items are in flight; results are held stable.
//   Reset clears all valid bits, the ring pointer, the three sample rings and
//   running sums, so the first nine averages ramp up from zero.
//   The running sum update is a single subtract/add per channel, which is the
//   only loop-carried path; everything after it is feed-forward.
module pressure_average_threshold_monitor (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // slave side
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // [11:0] pressure_sample, [23:12] upper_sample, [35:24] lower_sample,
    // [39:36] zero
    input  logic [patm_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    // master side
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [5:0] pressure_psi, [11:6] upper_psi, [17:12] lower_psi,
    // [19:18] level_status, [23:20] zero
    output logic [patm_pkg::OUT_TDATA_W-1:0]   o_m_tdata
);
    import patm_pkg::*;

    // valid bits: stage 0 input reg .. stage 4 last product; output valid separate
    logic [4:0] r_vld;
    logic       r_out_vld;
    logic [5:0] stg_rdy;   // stage k may load this cycle

    logic [SAMPLE_W-1:0] r_pressure_in;
    logic [SAMPLE_W-1:0] r_upper_in;
    logic [SAMPLE_W-1:0] r_lower_in;
    logic [POS_W-1:0]    r_pos;
    logic [POS_W-1:0]    n_pos;

    t_stage_en stage_en;

    logic [PSI_W-1:0] pressure_psi;
    logic [PSI_W-1:0] upper_psi;
    logic [PSI_W-1:0] lower_psi;
    logic [PSI_W-1:0] out_pressure_psi;
    logic [PSI_W-1:0] out_upper_psi;
    logic [PSI_W-1:0] out_lower_psi;
    t_level_status    out_status;

    // ready chain, from the output back to the input
    assign stg_rdy[5] = !r_out_vld || i_m_tready;
    assign stg_rdy[4] = !r_vld[4]  || stg_rdy[5];
    assign stg_rdy[3] = !r_vld[3]  || stg_rdy[4];
    assign stg_rdy[2] = !r_vld[2]  || stg_rdy[3];
    assign stg_rdy[1] = !r_vld[1]  || stg_rdy[2];
    assign stg_rdy[0] = !r_vld[0]  || stg_rdy[1];

    assign o_s_tready = stg_rdy[0];
    assign o_m_tvalid = r_out_vld;

    // state changes only for a real item entering the sum stage
    assign stage_en.upd = stg_rdy[1] && r_vld[0];
    assign stage_en.s2  = stg_rdy[2];
    assign stage_en.s3  = stg_rdy[3];
    assign stage_en.s4  = stg_rdy[4];

    assign n_pos = (r_pos == POS_W'(WINDOW - 1)) ? '0 : r_pos + POS_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
            r_pos     <= '0;
        end else begin
            if (stg_rdy[0]) r_vld[0] <= i_s_tvalid;
            if (stg_rdy[1]) r_vld[1] <= r_vld[0];
            if (stg_rdy[2]) r_vld[2] <= r_vld[1];
            if (stg_rdy[3]) r_vld[3] <= r_vld[2];
            if (stg_rdy[4]) r_vld[4] <= r_vld[3];
            if (stg_rdy[5]) r_out_vld <= r_vld[4];
            if (stage_en.upd) r_pos <= n_pos;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (stg_rdy[0]) begin
            r_pressure_in <= i_s_tdata[SAMPLE_W-1:0];
            r_upper_in    <= i_s_tdata[2*SAMPLE_W-1:SAMPLE_W];
            r_lower_in    <= i_s_tdata[3*SAMPLE_W-1:2*SAMPLE_W];
        end
    end

    patm_channel u_pressure (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (stage_en),
        .i_pos    (r_pos),
        .i_sample (r_pressure_in),
        .o_psi    (pressure_psi)
    );

    patm_channel u_upper (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (stage_en),
        .i_pos    (r_pos),
        .i_sample (r_upper_in),
        .o_psi    (upper_psi)
    );

    patm_channel u_lower (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (stage_en),
        .i_pos    (r_pos),
        .i_sample (r_lower_in),
        .o_psi    (lower_psi)
    );

    patm_status u_status (
        .i_clk          (i_clk),
        .i_load         (stg_rdy[5]),
        .i_pressure_psi (pressure_psi),
        .i_upper_psi    (upper_psi),
        .i_lower_psi    (lower_psi),
        .o_pressure_psi (out_pressure_psi),
        .o_upper_psi    (out_upper_psi),
        .o_lower_psi    (out_lower_psi),
        .o_level_status (out_status)
    );

    assign o_m_tdata = OUT_TDATA_W'({out_status, out_lower_psi, out_upper_psi,
                                     out_pressure_psi});

endmodule

// File: rtl/core/patm_checker.sv
// Port-level checks for the pressure average threshold monitor, with bind.
// Depends on patm_pkg and pressure_average_threshold_monitor.
module patm_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_m_tready,
    input logic                             o_m_tvalid,
    input logic [patm_pkg::OUT_TDATA_W-1:0] o_m_tdata
);
    import patm_pkg::*;

    logic [PSI_W-1:0]    chk_p;
    logic [PSI_W-1:0]    chk_u;
    logic [PSI_W-1:0]    chk_l;
    logic [STATUS_W-1:0] chk_s;

    assign chk_p = o_m_tdata[PSI_W-1:0];
    assign chk_u = o_m_tdata[2*PSI_W-1:PSI_W];
    assign chk_l = o_m_tdata[3*PSI_W-1:2*PSI_W];
    assign chk_s = o_m_tdata[3*PSI_W+STATUS_W-1:3*PSI_W];

    // stalled result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped while stalled");

    // stalled result holds its data
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata))
        else $error("result changed while stalled");

    // scaled values stay within span
    a_psi_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (32'(chk_p) <= PSI_SPAN) && (32'(chk_u) <= PSI_SPAN)
                       && (32'(chk_l) <= PSI_SPAN))
        else $error("scaled value above span");

    // status agrees with the values it travels with
    a_status_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |->
            ((chk_s == LEVEL_HIGH) && (chk_p >= chk_u))
         || ((chk_s == LEVEL_LOW) && (chk_p < chk_u) && (chk_p <= chk_l))
         || ((chk_s == LEVEL_NORMAL) && (chk_p < chk_u) && (chk_p > chk_l)))
        else $error("level status inconsistent with values");

endmodule

bind pressure_average_threshold_monitor patm_checker u_patm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tready (i_m_tready),
    .o_m_tvalid (o_m_tvalid),
    .o_m_tdata  (o_m_tdata)
);
